/* rtl/core/block_cache_fill_tracker_defines.svh */
`ifndef BLOCK_CACHE_FILL_TRACKER_DEFINES_SVH
`define BLOCK_CACHE_FILL_TRACKER_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BCFT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BCFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/bcft_pkg.sv */
`default_nettype none

package bcft_pkg;

	localparam int SEC_W      = 40;
	localparam int SHIFT_W    = 5;
	localparam int CNT_W      = 9;
	localparam int BLK_W      = 16;
	localparam int PEND_W     = 6;
	localparam int STAT_W     = 32;
	localparam int CACHED_W   = 17;
	localparam int CMD_W      = 2;
	localparam int CODE_W     = 2;
	localparam int CFG_IDX_W  = 1;

	localparam int NUM_BLOCKS_DEF      = 65536;
	localparam int MAX_REQ_SECTORS_DEF = 256;

	localparam logic [SHIFT_W-1:0] MIN_SHIFT = 5'd3;
	localparam logic [SHIFT_W-1:0] MAX_SHIFT = 5'd21;

	localparam logic [CMD_W-1:0] CMD_READ     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPLETE = 2'd2;

	localparam logic [CODE_W-1:0] KIND_COPY  = 2'd0;
	localparam logic [CODE_W-1:0] KIND_ROUTE = 2'd1;
	localparam logic [CODE_W-1:0] KIND_ACK   = 2'd2;

	localparam logic [CODE_W-1:0] TGT_ORIGIN = 2'd0;
	localparam logic [CODE_W-1:0] TGT_CACHE  = 2'd1;
	localparam logic [CODE_W-1:0] TGT_REJECT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CACHE_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SHIFT = 1'd1;

	localparam int MAP_VALID = 1;
	localparam int MAP_INFL  = 0;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_SHIFT_LO,
		ST_SHIFT_HI,
		ST_WALK,
		ST_DRAIN,
		ST_ROUTE,
		ST_CMPL
	} state_t;

	typedef struct packed {
		logic hit;
		logic miss;
		logic cached;
	} upd_t;

endpackage

`default_nettype wire

/* rtl/core/bcft_shift.sv */
`default_nettype none

module bcft_shift (
	input  wire logic [bcft_pkg::SEC_W:0]     value,
	input  wire logic [bcft_pkg::SHIFT_W-1:0] amount,
	output logic      [bcft_pkg::SEC_W:0]     shifted
);

	logic [bcft_pkg::SHIFT_W-1:0] amt_eff;

	always_comb begin
		if (amount < bcft_pkg::MIN_SHIFT) begin
			amt_eff = bcft_pkg::MIN_SHIFT;
		end else if (amount > bcft_pkg::MAX_SHIFT) begin
			amt_eff = bcft_pkg::MAX_SHIFT;
		end else begin
			amt_eff = amount;
		end
	end

	assign shifted = value >> amt_eff;

endmodule

`default_nettype wire

/* rtl/core/bcft_stats.sv */
`default_nettype none

module bcft_stats (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bcft_pkg::upd_t                upd,
	output logic [bcft_pkg::STAT_W-1:0]        hits,
	output logic [bcft_pkg::STAT_W-1:0]        misses,
	output logic [bcft_pkg::CACHED_W-1:0]      cached
);

	logic [bcft_pkg::STAT_W-1:0]   hits_q;
	logic [bcft_pkg::STAT_W-1:0]   misses_q;
	logic [bcft_pkg::CACHED_W-1:0] cached_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q   <= '0;
			misses_q <= '0;
			cached_q <= '0;
		end else begin
			if (upd.hit) begin
				hits_q <= hits_q + 1'b1;
			end
			if (upd.miss) begin
				misses_q <= misses_q + 1'b1;
			end
			if (upd.cached) begin
				cached_q <= cached_q + 1'b1;
			end
		end
	end

	assign hits   = hits_q;
	assign misses = misses_q;
	assign cached = cached_q;

endmodule

`default_nettype wire

/* rtl/core/block_cache_fill_tracker.sv */
// Block cache fill tracker: keeps a valid and an in-flight bit per cache block.
// Input beats are taken when start is high and busy is low; command selects a
// read request, a write request or a copy completion. Results leave one beat a
// cycle on result_strobe with kind, target, copy_block, pending_blocks, last
// and the running counters; the receiver cannot stall, so every strobed beat
// is final. Registers are written through cfg_we, cfg_index and cfg_wdata.
// A write request is answered in the cycle after it is taken. A completion is
// acknowledged from ST_CMPL. A read that goes to the origin device gives its
// route beat from ST_SHIFT_HI, after ST_PREP and ST_SHIFT_LO. A read served
// from the cache walks its k covered blocks through the bitmap memory (one
// read port, one write port), one block a cycle, emitting a copy beat for each
// miss, and gives the route beat from ST_ROUTE after ST_DRAIN; busy stays high
// meanwhile. After reset all NUM_BLOCKS bitmap entries are cleared, one entry
// a cycle, with busy high; configuration writes are taken throughout.
`default_nettype none

module block_cache_fill_tracker #(
	parameter int NUM_BLOCKS      = bcft_pkg::NUM_BLOCKS_DEF,
	parameter int MAX_REQ_SECTORS = bcft_pkg::MAX_REQ_SECTORS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bcft_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bcft_pkg::SEC_W-1:0]       cfg_wdata,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [bcft_pkg::CMD_W-1:0]       command,
	input  wire logic [bcft_pkg::SEC_W-1:0]       first_sector,
	input  wire logic [bcft_pkg::CNT_W-1:0]       sector_count,
	input  wire logic [bcft_pkg::BLK_W-1:0]       done_block,
	input  wire logic                             copy_failed,
	output logic                                  result_strobe,
	output logic [bcft_pkg::CODE_W-1:0]           kind,
	output logic [bcft_pkg::CODE_W-1:0]           target,
	output logic [bcft_pkg::BLK_W-1:0]            copy_block,
	output logic [bcft_pkg::PEND_W-1:0]           pending_blocks,
	output logic                                  last,
	output logic [bcft_pkg::STAT_W-1:0]           hit_count,
	output logic [bcft_pkg::STAT_W-1:0]           miss_count,
	output logic [bcft_pkg::CACHED_W-1:0]         cached_count
);

	`include "block_cache_fill_tracker_defines.svh"

	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int XW = bcft_pkg::SEC_W + 1;
	localparam logic [XW-1:0] MAX_EXT = XW'(MAX_REQ_SECTORS);
	localparam logic [XW-1:0] NUM_EXT = XW'(NUM_BLOCKS);
	localparam logic [BW-1:0] LAST_IDX = BW'(NUM_BLOCKS - 1);

	bcft_pkg::state_t state_q, state_d;

	logic [bcft_pkg::SEC_W-1:0]   cache_limit_q;
	logic [bcft_pkg::SHIFT_W-1:0] block_shift_q;
	logic                         bypass_q;
	logic [BW-1:0]                clr_q;
	logic                         ev_q;

	logic [bcft_pkg::SEC_W-1:0]   first_q;
	logic [bcft_pkg::CNT_W-1:0]   cnt_q;
	logic [bcft_pkg::BLK_W-1:0]   done_q;
	logic                         failed_q;
	logic [XW-1:0]                last_sec_q;
	logic                         over_q;
	logic [BW-1:0]                cur_q;
	logic [BW-1:0]                end_q;
	logic [BW-1:0]                ev_addr_q;
	logic [bcft_pkg::PEND_W-1:0]  pend_q;
	logic [1:0]                   rdata_q;

	logic                         res_strobe_q;
	logic [bcft_pkg::CODE_W-1:0]  kind_q;
	logic [bcft_pkg::CODE_W-1:0]  target_q;
	logic [bcft_pkg::BLK_W-1:0]   blk_q;
	logic [bcft_pkg::PEND_W-1:0]  pend_out_q;
	logic                         last_q;

	logic [1:0] map_mem [NUM_BLOCKS];

	logic                         accept;
	logic [XW-1:0]                cnt_eff;
	logic [XW-1:0]                sh_in;
	logic [XW-1:0]                sh_out;
	logic                         to_origin;
	logic [31:0]                  done_ext_in;
	logic [31:0]                  done_ext_q;
	logic                         done_in_range;
	logic [31:0]                  ev_blk_ext;
	logic [BW-1:0]                rd_addr;

	logic                         mem_we;
	logic [BW-1:0]                mem_waddr;
	logic [1:0]                   mem_wdata;
	bcft_pkg::upd_t               upd;
	logic                         emit;
	logic [bcft_pkg::CODE_W-1:0]  emit_kind;
	logic [bcft_pkg::CODE_W-1:0]  emit_target;
	logic [bcft_pkg::BLK_W-1:0]   emit_blk;
	logic [bcft_pkg::PEND_W-1:0]  emit_pend;
	logic                         emit_last;

	assign busy   = (state_q != bcft_pkg::ST_IDLE);
	assign accept = start && !busy;

	assign done_ext_in   = 32'(done_block);
	assign done_ext_q    = 32'(done_q);
	assign done_in_range = (done_ext_q < 32'(NUM_BLOCKS));
	assign ev_blk_ext    = 32'(ev_addr_q);

	always_comb begin
		if (cnt_q == '0) begin
			cnt_eff = XW'(1);
		end else if (XW'(cnt_q) > MAX_EXT) begin
			cnt_eff = MAX_EXT;
		end else begin
			cnt_eff = XW'(cnt_q);
		end
	end

	assign sh_in = (state_q == bcft_pkg::ST_SHIFT_LO) ? XW'(first_q) : last_sec_q;

	bcft_shift u_shift (
		.value   (sh_in),
		.amount  (block_shift_q),
		.shifted (sh_out)
	);

	assign to_origin = bypass_q || over_q || (sh_out >= NUM_EXT);
	assign rd_addr   = (state_q == bcft_pkg::ST_WALK) ? cur_q : done_ext_in[BW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			bcft_pkg::ST_CLEAR: begin
				if (clr_q == LAST_IDX) begin
					state_d = bcft_pkg::ST_IDLE;
				end
			end
			bcft_pkg::ST_IDLE: begin
				if (accept) begin
					case (command)
						bcft_pkg::CMD_READ:     state_d = bcft_pkg::ST_PREP;
						bcft_pkg::CMD_COMPLETE: state_d = bcft_pkg::ST_CMPL;
						default:                state_d = bcft_pkg::ST_IDLE;
					endcase
				end
			end
			bcft_pkg::ST_PREP:     state_d = bcft_pkg::ST_SHIFT_LO;
			bcft_pkg::ST_SHIFT_LO: state_d = bcft_pkg::ST_SHIFT_HI;
			bcft_pkg::ST_SHIFT_HI: begin
				state_d = to_origin ? bcft_pkg::ST_IDLE : bcft_pkg::ST_WALK;
			end
			bcft_pkg::ST_WALK: begin
				if (cur_q == end_q) begin
					state_d = bcft_pkg::ST_DRAIN;
				end
			end
			bcft_pkg::ST_DRAIN:    state_d = bcft_pkg::ST_ROUTE;
			bcft_pkg::ST_ROUTE:    state_d = bcft_pkg::ST_IDLE;
			bcft_pkg::ST_CMPL:     state_d = bcft_pkg::ST_IDLE;
			default:               state_d = bcft_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = ev_addr_q;
		mem_wdata   = 2'b00;
		upd         = '0;
		emit        = 1'b0;
		emit_kind   = bcft_pkg::KIND_COPY;
		emit_target = bcft_pkg::TGT_ORIGIN;
		emit_blk    = '0;
		emit_pend   = '0;
		emit_last   = 1'b0;
		case (state_q)
			bcft_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			bcft_pkg::ST_IDLE: begin
				if (accept && command == bcft_pkg::CMD_WRITE) begin
					emit        = 1'b1;
					emit_kind   = bcft_pkg::KIND_ROUTE;
					emit_target = bcft_pkg::TGT_REJECT;
					emit_last   = 1'b1;
				end
			end
			bcft_pkg::ST_SHIFT_HI: begin
				if (to_origin) begin
					emit        = 1'b1;
					emit_kind   = bcft_pkg::KIND_ROUTE;
					emit_target = bcft_pkg::TGT_ORIGIN;
					emit_last   = 1'b1;
				end
			end
			bcft_pkg::ST_WALK, bcft_pkg::ST_DRAIN: begin
				if (ev_q) begin
					if (rdata_q[bcft_pkg::MAP_VALID] || rdata_q[bcft_pkg::MAP_INFL]) begin
						upd.hit = 1'b1;
					end else begin
						upd.miss  = 1'b1;
						mem_we    = 1'b1;
						mem_wdata = 2'b01;
						emit      = 1'b1;
						emit_kind = bcft_pkg::KIND_COPY;
						emit_blk  = ev_blk_ext[bcft_pkg::BLK_W-1:0];
					end
				end
			end
			bcft_pkg::ST_ROUTE: begin
				emit        = 1'b1;
				emit_kind   = bcft_pkg::KIND_ROUTE;
				emit_target = bcft_pkg::TGT_CACHE;
				emit_pend   = pend_q;
				emit_last   = 1'b1;
			end
			bcft_pkg::ST_CMPL: begin
				emit      = 1'b1;
				emit_kind = bcft_pkg::KIND_ACK;
				emit_blk  = done_q;
				emit_last = 1'b1;
				if (done_in_range) begin
					mem_we    = 1'b1;
					mem_waddr = done_ext_q[BW-1:0];
					mem_wdata = {failed_q ? rdata_q[bcft_pkg::MAP_VALID] : 1'b1, 1'b0};
					upd.cached = !failed_q && !rdata_q[bcft_pkg::MAP_VALID];
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= bcft_pkg::ST_CLEAR;
			clr_q         <= '0;
			cache_limit_q <= '0;
			block_shift_q <= bcft_pkg::MIN_SHIFT;
			bypass_q      <= 1'b0;
			ev_q          <= 1'b0;
			res_strobe_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			ev_q         <= (state_q == bcft_pkg::ST_WALK);
			res_strobe_q <= emit;
			if (state_q == bcft_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == bcft_pkg::ST_CMPL && done_in_range && failed_q) begin
				bypass_q <= 1'b1;
			end
			if (cfg_we) begin
				case (cfg_index)
					bcft_pkg::REG_CACHE_LIMIT: cache_limit_q <= cfg_wdata;
					bcft_pkg::REG_BLOCK_SHIFT: block_shift_q <= cfg_wdata[bcft_pkg::SHIFT_W-1:0];
					default:                   cache_limit_q <= cache_limit_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			first_q  <= first_sector;
			cnt_q    <= sector_count;
			done_q   <= done_block;
			failed_q <= copy_failed;
		end
		case (state_q)
			bcft_pkg::ST_PREP: begin
				last_sec_q <= XW'(first_q) + cnt_eff - XW'(1);
			end
			bcft_pkg::ST_SHIFT_LO: begin
				over_q <= (last_sec_q > XW'(cache_limit_q));
				cur_q  <= sh_out[BW-1:0];
			end
			bcft_pkg::ST_SHIFT_HI: begin
				end_q  <= sh_out[BW-1:0];
				pend_q <= '0;
			end
			bcft_pkg::ST_WALK: begin
				cur_q     <= cur_q + 1'b1;
				ev_addr_q <= cur_q;
			end
			default: begin
				ev_addr_q <= ev_addr_q;
			end
		endcase
		if (ev_q && !rdata_q[bcft_pkg::MAP_VALID]) begin
			pend_q <= pend_q + 1'b1;
		end
		if (emit) begin
			kind_q     <= emit_kind;
			target_q   <= emit_target;
			blk_q      <= emit_blk;
			pend_out_q <= emit_pend;
			last_q     <= emit_last;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= map_mem[rd_addr];
	end

	bcft_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.hits   (hit_count),
		.misses (miss_count),
		.cached (cached_count)
	);

	assign result_strobe  = res_strobe_q;
	assign kind           = kind_q;
	assign target         = target_q;
	assign copy_block     = blk_q;
	assign pending_blocks = pend_out_q;
	assign last           = last_q;

	`BCFT_ASSERT_NEXT(a_write_rejected, clk, arst_n, accept && command == bcft_pkg::CMD_WRITE, result_strobe && last && target == bcft_pkg::TGT_REJECT, "write request was not rejected")
	`BCFT_ASSERT_NEXT(a_route_final, clk, arst_n, state_q == bcft_pkg::ST_ROUTE, result_strobe && last && kind == bcft_pkg::KIND_ROUTE && target == bcft_pkg::TGT_CACHE, "cache route beat missing")
	`BCFT_ASSERT_SAME(a_copy_not_last, clk, arst_n, result_strobe && kind == bcft_pkg::KIND_COPY, !last && target == bcft_pkg::TGT_ORIGIN && pending_blocks == '0, "copy beat is malformed")
	`BCFT_ASSERT_NEXT(a_idle_counts_stable, clk, arst_n, state_q == bcft_pkg::ST_IDLE, $stable(hit_count) && $stable(miss_count), "counters moved while idle")

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import bcft_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam logic [SEC_W-1:0] SECTOR_MAX  = {SEC_W{1'b1}};

	typedef struct {
		logic [CMD_W-1:0] cmd;
		logic [SEC_W-1:0] first;
		logic [CNT_W-1:0] count;
		logic [BLK_W-1:0] blk;
		logic             failed;
		bit               hold;
	} host_cmd_t;

	typedef struct packed {
		logic [CODE_W-1:0]   kind;
		logic [CODE_W-1:0]   target;
		logic [BLK_W-1:0]    blk;
		logic [PEND_W-1:0]   pend;
		logic                fin;
		logic [STAT_W-1:0]   hits;
		logic [STAT_W-1:0]   misses;
		logic [CACHED_W-1:0] cached;
	} fill_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_CACHE_LIMIT;
	logic [SEC_W-1:0]     cfg_wdata = '0;
	logic                 start = 1'b0;
	logic                 busy;
	logic [CMD_W-1:0]     command = CMD_READ;
	logic [SEC_W-1:0]     first_sector = '0;
	logic [CNT_W-1:0]     sector_count = '0;
	logic [BLK_W-1:0]     done_block = '0;
	logic                 copy_failed = 1'b0;
	logic                 result_strobe;
	logic [CODE_W-1:0]    kind;
	logic [CODE_W-1:0]    target;
	logic [BLK_W-1:0]     copy_block;
	logic [PEND_W-1:0]    pending_blocks;
	logic                 last;
	logic [STAT_W-1:0]    hit_count;
	logic [STAT_W-1:0]    miss_count;
	logic [CACHED_W-1:0]  cached_count;

	block_cache_fill_tracker DUT (.*);

	always #2 clk = ~clk;

	host_cmd_t        host_q[$];
	host_cmd_t        cur_req;
	fill_beat_t       owed_beats[$];
	logic [BLK_W-1:0] recent_blocks[$];
	int unsigned      issued_n = 0;
	int unsigned      taken_n = 0;
	int unsigned      predicted_n = 0;
	int unsigned      seen_n = 0;
	int unsigned      idle_pct = 0;
	int unsigned      gen_shift = 3;
	int               fail_n = 0;

	bit                  blk_valid[NUM_BLOCKS_DEF];
	bit                  blk_inflight[NUM_BLOCKS_DEF];
	bit                  bypass_on = 1'b0;
	logic [STAT_W-1:0]   hit_total = '0;
	logic [STAT_W-1:0]   miss_total = '0;
	logic [CACHED_W-1:0] cached_total = '0;
	logic [SEC_W-1:0]    limit_cfg = '0;
	logic [SHIFT_W-1:0]  shift_cfg = MIN_SHIFT;

	function automatic void owe_beat(input logic [CODE_W-1:0] k, input logic [CODE_W-1:0] t,
			input logic [BLK_W-1:0] b, input logic [PEND_W-1:0] p, input logic fin);
		owed_beats.push_back('{k, t, b, p, fin, hit_total, miss_total, cached_total});
		predicted_n++;
	endfunction

	task automatic track_request(input host_cmd_t it);
		logic [63:0]       n_sec;
		logic [63:0]       last_sec;
		logic [63:0]       end_blk;
		logic [63:0]       b;
		int unsigned       sh;
		logic [PEND_W-1:0] pend;
		sh = shift_cfg;
		if (sh < MIN_SHIFT)
			sh = MIN_SHIFT;
		if (sh > MAX_SHIFT)
			sh = MAX_SHIFT;
		pend = '0;
		case (it.cmd)
			CMD_WRITE: owe_beat(KIND_ROUTE, TGT_REJECT, '0, '0, 1'b1);
			CMD_COMPLETE: begin
				if (int'(it.blk) < NUM_BLOCKS_DEF) begin
					if (it.failed) begin
						bypass_on = 1'b1;
					end else if (!blk_valid[it.blk]) begin
						blk_valid[it.blk] = 1'b1;
						cached_total++;
					end
					blk_inflight[it.blk] = 1'b0;
				end
				owe_beat(KIND_ACK, TGT_ORIGIN, it.blk, '0, 1'b1);
			end
			CMD_READ: begin
				n_sec = 64'(it.count);
				if (n_sec == 0)
					n_sec = 1;
				if (n_sec > MAX_REQ_SECTORS_DEF)
					n_sec = MAX_REQ_SECTORS_DEF;
				last_sec = 64'(it.first) + n_sec - 1;
				end_blk = last_sec >> sh;
				if (bypass_on || last_sec > 64'(limit_cfg) || end_blk >= NUM_BLOCKS_DEF) begin
					owe_beat(KIND_ROUTE, TGT_ORIGIN, '0, '0, 1'b1);
				end else begin
					for (b = 64'(it.first) >> sh; b <= end_blk; b++) begin
						if (blk_valid[b[BLK_W-1:0]]) begin
							hit_total++;
						end else if (blk_inflight[b[BLK_W-1:0]]) begin
							hit_total++;
							pend++;
						end else begin
							miss_total++;
							blk_inflight[b[BLK_W-1:0]] = 1'b1;
							pend++;
							owe_beat(KIND_COPY, TGT_ORIGIN, b[BLK_W-1:0], '0, 1'b0);
						end
					end
					owe_beat(KIND_ROUTE, TGT_CACHE, '0, pend, 1'b1);
				end
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : feed_requests
		host_cmd_t nxt;
		bit        launch;
		if (!arst_n) begin
			start <= 1'b0;
			taken_n <= 0;
		end else begin
			launch = 1'b0;
			if (start && !busy) begin
				track_request(cur_req);
				taken_n <= taken_n + 1;
			end
			if ((!start || !busy) && host_q.size() != 0 && $urandom_range(99) >= idle_pct &&
					(!host_q[0].hold || seen_n >= predicted_n)) begin
				nxt = host_q.pop_front();
				cur_req = nxt;
				launch = 1'b1;
				command <= nxt.cmd;
				first_sector <= nxt.first;
				sector_count <= nxt.count;
				done_block <= nxt.blk;
				copy_failed <= nxt.failed;
			end
			start <= launch || (start && busy);
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch_results
		fill_beat_t got;
		fill_beat_t want;
		if (!arst_n) begin
			seen_n <= 0;
		end else if (result_strobe) begin
			got = '{kind, target, copy_block, pending_blocks, last, hit_count, miss_count,
				cached_count};
			if (owed_beats.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual kind=%0d target=%0d block=%0d",
					$time, got.kind, got.target, got.blk);
				fail_n++;
			end else begin
				want = owed_beats.pop_front();
				if (got !== want) begin
					$display("%0t: beat mismatch, expected kind=%0d target=%0d block=%0d pend=%0d last=%0d hits=%0d misses=%0d cached=%0d",
						$time, want.kind, want.target, want.blk, want.pend, want.fin,
						want.hits, want.misses, want.cached);
					$display("%0t: beat mismatch, actual   kind=%0d target=%0d block=%0d pend=%0d last=%0d hits=%0d misses=%0d cached=%0d",
						$time, got.kind, got.target, got.blk, got.pend, got.fin,
						got.hits, got.misses, got.cached);
					fail_n++;
				end
			end
			seen_n <= seen_n + 1;
		end
	end

	function automatic logic [SEC_W-1:0] rand_sector();
		return {8'($urandom), 32'($urandom)};
	endfunction

	task automatic add_item(input logic [CMD_W-1:0] cmd, input logic [SEC_W-1:0] first,
			input logic [CNT_W-1:0] count, input logic [BLK_W-1:0] blk, input logic failed,
			input bit hold);
		host_q.push_back('{cmd, first, count, blk, failed, hold});
		issued_n++;
	endtask

	task automatic add_read(input logic [SEC_W-1:0] first, input logic [CNT_W-1:0] count,
			input bit hold);
		logic [63:0] n_sec;
		logic [63:0] end_blk;
		logic [63:0] b;
		n_sec = (count == 0) ? 1 : (count > MAX_REQ_SECTORS_DEF) ? MAX_REQ_SECTORS_DEF : count;
		end_blk = (64'(first) + n_sec - 1) >> gen_shift;
		if (end_blk < NUM_BLOCKS_DEF) begin
			for (b = 64'(first) >> gen_shift; b <= end_blk; b++)
				recent_blocks.push_back(b[BLK_W-1:0]);
			while (recent_blocks.size() > 128)
				void'(recent_blocks.pop_front());
		end
		add_item(CMD_READ, first, count, BLK_W'($urandom), 1'($urandom), hold);
	endtask

	task automatic add_random(input int unsigned fail_pct);
		int unsigned      pick;
		int unsigned      idx;
		logic [63:0]      base;
		logic [CNT_W-1:0] cnt;
		logic [BLK_W-1:0] blk;
		bit               hold;
		pick = $urandom_range(99);
		hold = ($urandom_range(99) < 3);
		blk = BLK_W'($urandom);
		if (pick < 50) begin
			base = ($urandom_range(99) < 85) ? $urandom_range(300) : $urandom_range(65535, 65500);
			base = (base << gen_shift) + $urandom_range((1 << gen_shift) - 1);
			pick = $urandom_range(99);
			if (pick < 10)
				cnt = '0;
			else if (pick < 20)
				cnt = CNT_W'($urandom_range(511, 257));
			else
				cnt = CNT_W'($urandom_range(256, 1));
			add_read(SEC_W'(base), cnt, hold);
		end else if (pick < 78) begin
			if (recent_blocks.size() != 0 && $urandom_range(99) < 90) begin
				idx = $urandom_range(recent_blocks.size() - 1);
				blk = recent_blocks[idx];
				recent_blocks.delete(idx);
			end
			add_item(CMD_COMPLETE, rand_sector(), CNT_W'($urandom), blk,
				$urandom_range(99) < fail_pct, hold);
		end else if (pick < 88) begin
			add_item(CMD_WRITE, rand_sector(), CNT_W'($urandom), blk, 1'($urandom), hold);
		end else if (pick < 93) begin
			add_item(CMD_UNKNOWN, rand_sector(), CNT_W'($urandom), blk, 1'($urandom), hold);
		end else begin
			add_read(rand_sector(), CNT_W'($urandom), hold);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEC_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CACHE_LIMIT)
			limit_cfg = value;
		else
			shift_cfg = value[SHIFT_W-1:0];
		gen_shift = (shift_cfg < MIN_SHIFT) ? MIN_SHIFT :
			(shift_cfg > MAX_SHIFT) ? MAX_SHIFT : shift_cfg;
	endtask

	// Commands with no result may still be in the block, so wait out a full walk.
	task automatic drain_phase();
		while (taken_n != issued_n)
			@(posedge clk);
		while (seen_n < predicted_n)
			@(posedge clk);
		repeat (48) @(posedge clk);
	endtask

	task automatic start_phase(input logic [SEC_W-1:0] limit, input logic [SEC_W-1:0] shift,
			input int unsigned idle);
		write_reg(REG_CACHE_LIMIT, limit);
		write_reg(REG_BLOCK_SHIFT, shift);
		idle_pct <= idle;
		recent_blocks.delete();
	endtask

	initial begin
		#4ms;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		start_phase(SECTOR_MAX, 3, 0);
		add_read(0, 1, 0);
		add_read(0, 0, 0);
		add_read(5, 256, 0);
		add_read(1000, 511, 0);
		add_item(CMD_WRITE, SECTOR_MAX, {CNT_W{1'b1}}, {BLK_W{1'b1}}, 1'b0, 0);
		add_item(CMD_UNKNOWN, rand_sector(), CNT_W'($urandom), BLK_W'($urandom), 1'b0, 0);
		add_item(CMD_COMPLETE, '0, '0, 0, 1'b0, 0);
		add_item(CMD_COMPLETE, '0, '0, 0, 1'b0, 0);
		add_item(CMD_COMPLETE, '0, '0, 65535, 1'b0, 0);
		add_read(524280, 8, 1);
		add_read(524280, 9, 0);
		add_read(SECTOR_MAX, 256, 0);
		add_read(8, 8, 0);
		add_item(CMD_COMPLETE, '0, '0, 1, 1'b0, 0);
		add_read(0, 48, 0);
		drain_phase();

		start_phase(1000, 0, 49);
		add_read(993, 8, 0);
		add_read(994, 8, 0);
		add_read(1000, 1, 0);
		repeat (40) add_random(0);
		drain_phase();

		start_phase(SECTOR_MAX, 31, 22);
		add_read(SEC_W'(64'd65535 << 21), 1, 0);
		add_read(SEC_W'((64'd65536 << 21) - 1), 2, 0);
		repeat (60) add_random(0);
		drain_phase();

		start_phase(0, 21, 0);
		add_read(0, 1, 0);
		add_read(0, 2, 0);
		add_read(0, 0, 0);
		repeat (20) add_random(0);
		drain_phase();

		start_phase(rand_sector(), $urandom_range(31), 49);
		repeat (100) add_random(0);
		drain_phase();

		start_phase(SECTOR_MAX, 3, 22);
		repeat (90) add_random(0);
		add_item(CMD_COMPLETE, rand_sector(), CNT_W'($urandom), BLK_W'($urandom), 1'b1, 1);
		repeat (15) add_random(20);
		drain_phase();

		if (owed_beats.size() != 0)
			fail_n++;
		if (fail_n == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
